[design/mtrf_pkg.sv]
// Package for the median threshold run finder.
// Holds the shared widths, constants and enum types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtrf_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 7;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int BIT_IDX_W   = 4;
  localparam int MED2_W      = SAMPLE_W + 1;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * IDX_W;

  // Flips the sign bit so signed order becomes unsigned order
  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

  // Register reset values
  localparam logic [CFG_W-1:0] MIN_WIDTH_RST = 8'd1;
  localparam logic [CFG_W-1:0] MAX_WIDTH_RST = 8'd128;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH = 2'd0,
    CFG_MAX_WIDTH = 2'd1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD  = 2'd0,
    ST_SEL   = 2'd1,
    ST_SCAN  = 2'd2,
    ST_FLUSH = 2'd3
  } state_e;

endpackage

`default_nettype wire

[design/mtrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the frame sample store.
`timescale 1ns / 1ps
`default_nettype none

module mtrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/median_threshold_run_finder.sv]
// Median threshold run finder: top level with sequencer and run scan.
// Depends on mtrf_pkg and mtrf_ram.
// Samples are taken one per cycle while loading; after the last sample of a frame
// the median select makes one shared compare-and-count pass over the stored samples
// per result bit (a second series for an even count), then the scan reads them once
// more, waiting on output stalls, and a flush state sends the last result. Input is held off meanwhile.
// Reset clears control and sets min_width to 1, max_width to 128; the sample
// memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module median_threshold_run_finder #(
  parameter int FRAME_DEPTH = 128
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Config write port
  input  wire logic                               cfg_we_i,
  input  wire logic [mtrf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mtrf_pkg::CFG_W-1:0]         cfg_data_i,
  // Sample stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [mtrf_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [15:0] sample
  input  wire logic                               s_axis_tlast,  // last
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic      [mtrf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [6:0] run_start, [13:7] run_end
  output logic                                    m_axis_tuser,  // found
  output logic                                    m_axis_tlast   // last_result
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int SW = mtrf_pkg::SAMPLE_W;

  mtrf_pkg::state_e state_q, state_d;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  addr_q, addr_d;
  logic [CW-1:0]  hits_q, hits_d;
  logic           rd_v_q, rd_v_d;
  logic [mtrf_pkg::BIT_IDX_W-1:0] bit_q, bit_d;
  logic [SW-1:0]  ans_q, ans_d;
  logic [SW-1:0]  med_a_q, med_a_d;
  logic           sel_hi_q, sel_hi_d;
  logic [mtrf_pkg::MED2_W-1:0] m2_q, m2_d;

  logic           run_open_q, run_open_d;
  logic [AW-1:0]  run_left_q, run_left_d;
  logic           pend_v_q, pend_v_d;
  logic [AW-1:0]  pend_start_q, pend_start_d;
  logic [AW-1:0]  pend_end_q, pend_end_d;

  logic           out_v_q, out_v_d;
  logic           out_found_q, out_found_d;
  logic [AW-1:0]  out_start_q, out_start_d;
  logic [AW-1:0]  out_end_q, out_end_d;
  logic           out_last_q, out_last_d;

  logic [mtrf_pkg::CFG_W-1:0] min_q, max_q;

  // Memory and datapath signals
  logic           ram_we, ram_re;
  logic [SW-1:0]  ram_rdata;
  logic           s_acc, has_room, in_range, hit, take_bit, above, qual;
  logic           close_run, push, stall, out_full;
  logic [CW-1:0]  data_idx, hits_tot, k_sel, run_w;
  logic [SW-1:0]  trial, rd_u, ans_new, sel_val;
  logic [mtrf_pkg::CFG_W-1:0] run_w8;

  mtrf_ram #(
    .WIDTH (SW),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mtrf_pkg::MIN_WIDTH_RST;
      max_q <= mtrf_pkg::MAX_WIDTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mtrf_pkg::CFG_MIN_WIDTH: min_q <= cfg_data_i;
        mtrf_pkg::CFG_MAX_WIDTH: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shared datapath terms
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign has_room = cnt_q < CW'(FRAME_DEPTH);
  assign in_range = addr_q < cnt_q;
  assign data_idx = addr_q - CW'(1);

  // Bitwise select: count samples below the trial value
  assign trial    = ans_q | (SW'(1) << bit_q);
  assign rd_u     = ram_rdata ^ mtrf_pkg::SIGN_FLIP;
  assign hit      = rd_u < trial;
  assign hits_tot = hits_q + CW'(hit);
  assign k_sel    = sel_hi_q ? (cnt_q >> 1) : ((cnt_q - CW'(1)) >> 1);
  assign take_bit = hits_tot <= k_sel;
  assign ans_new  = take_bit ? trial : ans_q;
  assign sel_val  = ans_new ^ mtrf_pkg::SIGN_FLIP;

  // Scan: compare doubled sample to doubled median
  assign above     = $signed({ram_rdata, 1'b0}) > $signed(m2_q);
  assign run_w     = data_idx - CW'(run_left_q);
  assign run_w8    = mtrf_pkg::CFG_W'(run_w);
  assign qual      = (run_w8 >= min_q) && (run_w8 <= max_q);
  assign out_full  = out_v_q && !m_axis_tready;
  assign close_run = (state_q == mtrf_pkg::ST_SCAN) && rd_v_q && run_open_q && !above;
  assign push      = close_run && qual;
  assign stall     = push && pend_v_q && out_full;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    hits_d       = hits_q;
    rd_v_d       = rd_v_q;
    bit_d        = bit_q;
    ans_d        = ans_q;
    med_a_d      = med_a_q;
    sel_hi_d     = sel_hi_q;
    m2_d         = m2_q;
    run_open_d   = run_open_q;
    run_left_d   = run_left_q;
    pend_v_d     = pend_v_q;
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    out_v_d      = out_v_q && !m_axis_tready;
    out_found_d  = out_found_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      mtrf_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_acc) begin
          ram_we = has_room;
          if (has_room) begin
            cnt_d = cnt_q + CW'(1);
          end
          if (s_axis_tlast) begin
            addr_d   = '0;
            rd_v_d   = 1'b0;
            hits_d   = '0;
            bit_d    = '1;
            ans_d    = '0;
            sel_hi_d = 1'b0;
            state_d  = mtrf_pkg::ST_SEL;
          end
        end
      end

      mtrf_pkg::ST_SEL: begin
        ram_re = in_range;
        rd_v_d = in_range;
        if (in_range) begin
          addr_d = addr_q + CW'(1);
        end
        if (rd_v_q) begin
          hits_d = hits_tot;
        end
        // End of a pass: settle one bit of the selected value
        if (rd_v_q && !in_range) begin
          hits_d = '0;
          addr_d = '0;
          ans_d  = ans_new;
          bit_d  = bit_q - mtrf_pkg::BIT_IDX_W'(1);
          if (bit_q == '0) begin
            ans_d = '0;
            bit_d = '1;
            if (!sel_hi_q && !cnt_q[0]) begin
              // even count: second middle value still needed
              med_a_d  = sel_val;
              sel_hi_d = 1'b1;
            end else begin
              if (sel_hi_q) begin
                m2_d = {med_a_q[SW-1], med_a_q} + {sel_val[SW-1], sel_val};
              end else begin
                m2_d = {sel_val[SW-1], sel_val} + {sel_val[SW-1], sel_val};
              end
              run_open_d = 1'b0;
              state_d    = mtrf_pkg::ST_SCAN;
            end
          end
        end
      end

      mtrf_pkg::ST_SCAN: begin
        ram_re = in_range && !stall;
        rd_v_d = (in_range && !stall) || stall;
        if (in_range && !stall) begin
          addr_d = addr_q + CW'(1);
        end
        if (rd_v_q && !stall) begin
          if (!run_open_q && above) begin
            run_open_d = 1'b1;
            run_left_d = data_idx[AW-1:0];
          end else if (close_run) begin
            run_open_d = 1'b0;
            if (push) begin
              // older pending run goes out, newest waits for its last flag
              if (pend_v_q) begin
                out_v_d     = 1'b1;
                out_found_d = 1'b1;
                out_start_d = pend_start_q;
                out_end_d   = pend_end_q;
                out_last_d  = 1'b0;
              end
              pend_v_d     = 1'b1;
              pend_start_d = run_left_q;
              pend_end_d   = data_idx[AW-1:0];
            end
          end
          if (!in_range) begin
            state_d = mtrf_pkg::ST_FLUSH;
          end
        end
      end

      mtrf_pkg::ST_FLUSH: begin
        if (!out_full) begin
          out_v_d     = 1'b1;
          out_found_d = pend_v_q;
          out_start_d = pend_v_q ? pend_start_q : '0;
          out_end_d   = pend_v_q ? pend_end_q : '0;
          out_last_d  = 1'b1;
          pend_v_d    = 1'b0;
          cnt_d       = '0;
          run_open_d  = 1'b0;
          run_left_d  = '0;
          state_d     = mtrf_pkg::ST_LOAD;
        end
      end

      default: state_d = mtrf_pkg::ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mtrf_pkg::ST_LOAD;
      cnt_q      <= '0;
      addr_q     <= '0;
      hits_q     <= '0;
      rd_v_q     <= 1'b0;
      bit_q      <= '0;
      sel_hi_q   <= 1'b0;
      run_open_q <= 1'b0;
      run_left_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      addr_q     <= addr_d;
      hits_q     <= hits_d;
      rd_v_q     <= rd_v_d;
      bit_q      <= bit_d;
      sel_hi_q   <= sel_hi_d;
      run_open_q <= run_open_d;
      run_left_q <= run_left_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ans_q        <= ans_d;
    med_a_q      <= med_a_d;
    m2_q         <= m2_d;
    pend_start_q <= pend_start_d;
    pend_end_q   <= pend_end_d;
    out_found_q  <= out_found_d;
    out_start_q  <= out_start_d;
    out_end_q    <= out_end_d;
    out_last_q   <= out_last_d;
  end

  // Result stream
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{mtrf_pkg::OUT_PAD_W{1'b0}},
                          mtrf_pkg::IDX_W'(out_end_q),
                          mtrf_pkg::IDX_W'(out_start_q)};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
